[rtl/core/multi_slot_loop_timer_assert.svh]
// Assertion macros for the multi slot loop timer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MULTI_SLOT_LOOP_TIMER_ASSERT_SVH
`define MULTI_SLOT_LOOP_TIMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MSLT_ASSERT_IMPL(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mslt check failed");
`define MSLT_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mslt check failed");
`else
`define MSLT_ASSERT_IMPL(name, clk, rst, pre, post)
`define MSLT_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

[rtl/core/mslt_pkg.sv]
// Shared constants and control types for the multi slot loop timer.
// No dependencies.
package mslt_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  localparam int PERIOD_W  = 32;
  localparam int LOOP_W    = 16;
  localparam int TICK_W    = 16;
  localparam int KIND_W    = 3;
  localparam int SLOT_ID_W = 4;

  localparam logic [KIND_W-1:0] KIND_SET_OK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELOAD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FINISH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd4;

  typedef struct packed {
    logic              capture;
    logic              tick_add;
    logic              rd_en;
    logic              set_wr;
    logic              fire_wr;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
    logic              zero_slot;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic fire;
    logic finish;
    logic out_free;
  } status_t;

endpackage

[rtl/core/mslt_if.sv]
// Request and result channel interfaces (valid/ready) of the timer.
// Depends on mslt_pkg for field widths.
interface mslt_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [mslt_pkg::PERIOD_W-1:0]  period;
  logic [mslt_pkg::LOOP_W-1:0]    loop_total;
  logic [mslt_pkg::PERIOD_W-1:0]  first_wait;
  logic                           use_first_wait;
  logic [mslt_pkg::TICK_W-1:0]    tick_amount;

  modport source (output valid, req_type, period, loop_total, first_wait, use_first_wait,
                  tick_amount, input ready);
  modport sink (input valid, req_type, period, loop_total, first_wait, use_first_wait,
                tick_amount, output ready);
endinterface

interface mslt_res_if;
  logic                            valid;
  logic                            ready;
  logic [mslt_pkg::KIND_W-1:0]     res_kind;
  logic [mslt_pkg::SLOT_ID_W-1:0]  slot_id;
  logic                            last_result;

  modport source (output valid, res_kind, slot_id, last_result, input ready);
  modport sink (input valid, res_kind, slot_id, last_result, output ready);
endinterface

[rtl/core/mslt_datapath.sv]
// Datapath: time counter, slot valid bits, slot record memory, fire
// evaluation and the result output register. Depends on mslt_pkg.
module mslt_datapath #(
  parameter int SLOT_COUNT = mslt_pkg::SLOT_COUNT_DEF,
  parameter int TIME_BITS  = mslt_pkg::TIME_BITS_DEF,
  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mslt_pkg::cmd_t                 cmd,
  input  logic [SLOT_W-1:0]              idx,
  input  logic [SLOT_W-1:0]              rd_addr,
  input  logic [mslt_pkg::PERIOD_W-1:0]  period,
  input  logic [mslt_pkg::LOOP_W-1:0]    loop_total,
  input  logic [mslt_pkg::PERIOD_W-1:0]  first_wait,
  input  logic                           use_first_wait,
  input  logic [mslt_pkg::TICK_W-1:0]    tick_amount,
  input  logic                           res_ready,
  output logic                           res_valid,
  output logic [mslt_pkg::KIND_W-1:0]    res_kind,
  output logic [mslt_pkg::SLOT_ID_W-1:0] res_slot,
  output logic                           res_last,
  output mslt_pkg::status_t              st
);

  localparam int CMP_W = (TIME_BITS > mslt_pkg::PERIOD_W) ? TIME_BITS : mslt_pkg::PERIOD_W;
  localparam int SUM_W = (TIME_BITS > mslt_pkg::TICK_W) ? TIME_BITS : mslt_pkg::TICK_W;

  logic [TIME_BITS-1:0] now_time;
  logic [SLOT_COUNT-1:0] slot_valid;

  logic [mslt_pkg::PERIOD_W-1:0] req_period;
  logic [mslt_pkg::LOOP_W-1:0]   req_loops;
  logic [mslt_pkg::PERIOD_W-1:0] req_first_wait;
  logic                          req_use_fw;

  logic [TIME_BITS-1:0]          mem_start      [SLOT_COUNT];
  logic [mslt_pkg::PERIOD_W-1:0] mem_period     [SLOT_COUNT];
  logic [mslt_pkg::PERIOD_W-1:0] mem_first_wait [SLOT_COUNT];
  logic                          mem_pending    [SLOT_COUNT];
  logic [mslt_pkg::LOOP_W-1:0]   mem_loops      [SLOT_COUNT];
  logic                          mem_forever    [SLOT_COUNT];

  logic [TIME_BITS-1:0]          rd_start;
  logic [mslt_pkg::PERIOD_W-1:0] rd_period;
  logic [mslt_pkg::PERIOD_W-1:0] rd_first_wait;
  logic                          rd_pending;
  logic [mslt_pkg::LOOP_W-1:0]   rd_loops;
  logic                          rd_forever;

  logic [SUM_W-1:0]              time_sum;
  logic [TIME_BITS-1:0]          elapsed;
  logic [mslt_pkg::PERIOD_W-1:0] cur_wait;

  assign time_sum = SUM_W'(now_time) + SUM_W'(tick_amount);
  assign elapsed  = now_time - rd_start;
  assign cur_wait = rd_pending ? rd_first_wait : rd_period;

  assign st.slot_free = !slot_valid[idx];
  assign st.fire      = slot_valid[idx] && (CMP_W'(elapsed) >= CMP_W'(cur_wait));
  assign st.finish    = !rd_forever && (rd_loops == mslt_pkg::LOOP_W'(1));
  assign st.out_free  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time <= '0;
    end else if (cmd.tick_add) begin
      now_time <= time_sum[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_period     <= period;
      req_loops      <= loop_total;
      req_first_wait <= first_wait;
      req_use_fw     <= use_first_wait;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.set_wr) begin
      slot_valid[idx] <= 1'b1;
    end else if (cmd.fire_wr && st.finish) begin
      slot_valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_wr) begin
      mem_start[idx]      <= now_time;
      mem_period[idx]     <= req_period;
      mem_first_wait[idx] <= req_first_wait;
      mem_pending[idx]    <= req_use_fw;
      mem_loops[idx]      <= req_loops;
      mem_forever[idx]    <= (req_loops == '0);
    end else if (cmd.fire_wr) begin
      mem_start[idx]   <= now_time;
      mem_pending[idx] <= 1'b0;
      mem_loops[idx]   <= rd_forever ? rd_loops : rd_loops - mslt_pkg::LOOP_W'(1);
    end
    if (cmd.rd_en) begin
      rd_start      <= mem_start[rd_addr];
      rd_period     <= mem_period[rd_addr];
      rd_first_wait <= mem_first_wait[rd_addr];
      rd_pending    <= mem_pending[rd_addr];
      rd_loops      <= mem_loops[rd_addr];
      rd_forever    <= mem_forever[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_kind <= cmd.kind;
      res_slot <= cmd.zero_slot ? '0 : mslt_pkg::SLOT_ID_W'(idx);
      res_last <= cmd.last;
    end
  end

endmodule

[rtl/core/mslt_ctrl.sv]
// Controller: sequences set probes and tick scans over the slot index.
// Depends on mslt_pkg and multi_slot_loop_timer_assert.svh.
`include "multi_slot_loop_timer_assert.svh"
module mslt_ctrl #(
  parameter int SLOT_COUNT = mslt_pkg::SLOT_COUNT_DEF,
  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_tick,
  output logic              in_ready,
  input  mslt_pkg::status_t st,
  output mslt_pkg::cmd_t    cmd,
  output logic [SLOT_W-1:0] idx,
  output logic [SLOT_W-1:0] rd_addr
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SET  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [SLOT_W-1:0] idx_next;
  logic [SLOT_W-1:0] idx_inc;

  assign idx_inc = idx + SLOT_W'(1);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    in_ready   = 1'b0;
    rd_addr    = idx;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        idx_next = '0;
        if (in_valid) begin
          if (in_tick) begin
            cmd.tick_add = 1'b1;
            state_next   = S_RD;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_SET;
          end
        end
      end
      S_SET: begin
        if (st.slot_free) begin
          if (st.out_free) begin
            cmd.set_wr = 1'b1;
            cmd.emit   = 1'b1;
            cmd.kind   = mslt_pkg::KIND_SET_OK;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (idx == LAST_SLOT) begin
          if (st.out_free) begin
            cmd.emit      = 1'b1;
            cmd.kind      = mslt_pkg::KIND_FULL;
            cmd.last      = 1'b1;
            cmd.zero_slot = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!st.fire || st.out_free) begin
          if (st.fire) begin
            cmd.fire_wr = 1'b1;
            cmd.emit    = 1'b1;
            cmd.kind    = st.finish ? mslt_pkg::KIND_FINISH : mslt_pkg::KIND_RELOAD;
          end
          if (idx == LAST_SLOT) begin
            state_next = S_DONE;
          end else begin
            idx_next  = idx_inc;
            rd_addr   = idx_inc;
            cmd.rd_en = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = mslt_pkg::KIND_DONE;
          cmd.last      = 1'b1;
          cmd.zero_slot = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  `MSLT_ASSERT_IMPL(emit_needs_room, clk, rst, cmd.emit, st.out_free)
  `MSLT_ASSERT_IMPL(set_into_free_slot, clk, rst, cmd.set_wr, st.slot_free)
  `MSLT_ASSERT_IMPL(fire_reports, clk, rst, cmd.fire_wr, cmd.emit && !cmd.last)
  `MSLT_ASSERT_NEXT(accept_leaves_idle, clk, rst, in_valid && in_ready, state != S_IDLE)

endmodule

[rtl/core/multi_slot_loop_timer.sv]
// Multi slot loop timer: SLOT_COUNT periodic timer slots on a shared TIME_BITS tick counter.
// A set request probes the valid bits one slot per cycle; a tick request scans the slot
// memory through its single read port, one slot per cycle while the result side does not
// stall. Either one waits while the result side stalls. One request is in work at a time;
// the final result sits in an output register while the next request is accepted. No
// clearing pass follows reset.
// Depends on mslt_pkg, mslt_if, mslt_ctrl and mslt_datapath.
module multi_slot_loop_timer #(
  parameter int SLOT_COUNT = mslt_pkg::SLOT_COUNT_DEF,
  parameter int TIME_BITS  = mslt_pkg::TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  mslt_req_if.sink  req,
  mslt_res_if.source res
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  mslt_pkg::cmd_t    cmd;
  mslt_pkg::status_t st;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] rd_addr;
  logic              in_ready;

  assign req.ready = in_ready;

  mslt_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_tick  (req.req_type),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd),
    .idx      (idx),
    .rd_addr  (rd_addr)
  );

  mslt_datapath #(
    .SLOT_COUNT(SLOT_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .idx            (idx),
    .rd_addr        (rd_addr),
    .period         (req.period),
    .loop_total     (req.loop_total),
    .first_wait     (req.first_wait),
    .use_first_wait (req.use_first_wait),
    .tick_amount    (req.tick_amount),
    .res_ready      (res.ready),
    .res_valid      (res.valid),
    .res_kind       (res.res_kind),
    .res_slot       (res.slot_id),
    .res_last       (res.last_result),
    .st             (st)
  );

endmodule

[sim/timer_req_pkg.sv]
// Request codes and the request item type shared by the timer testbench files.
// Depends on mslt_pkg for the field widths.
package timer_req_pkg;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic [mslt_pkg::PERIOD_W-1:0] period;
    logic [mslt_pkg::LOOP_W-1:0]   loop_total;
    logic [mslt_pkg::PERIOD_W-1:0] first_wait;
    logic                          use_first_wait;
    logic [mslt_pkg::TICK_W-1:0]   tick_amount;
  } timer_request_t;

endpackage

[sim/mslt_result_checker.sv]
// Watches the request and result channels of the loop timer, keeps its own slot table
// and time count, and compares every result item with the predicted one.
// Depends on mslt_pkg, timer_req_pkg and the mslt_req_if / mslt_res_if interfaces.
module mslt_result_checker
  import mslt_pkg::*, timer_req_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mslt_req_if  req,
  mslt_res_if  res,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int SHOWN = 10;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_ID_W-1:0] slot;
    logic                 last;
  } timer_result_t;

  logic [TIME_BITS_DEF-1:0] clock_now;
  bit                       busy       [SLOTS];
  logic [TIME_BITS_DEF-1:0] base_time  [SLOTS];
  logic [PERIOD_W-1:0]      slot_period[SLOTS];
  logic [PERIOD_W-1:0]      first_delay[SLOTS];
  bit                       delay_due  [SLOTS];
  logic [LOOP_W-1:0]        loops_left [SLOTS];
  bit                       endless    [SLOTS];
  timer_result_t            expected_results[$];
  int                       failures = 0;

  function automatic void add_result(logic [KIND_W-1:0] kind, int slot, logic last);
    timer_result_t r;
    r.kind = kind;
    r.slot = SLOT_ID_W'(slot);
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(timer_request_t item);
    logic [TIME_BITS_DEF-1:0] elapsed;
    logic [PERIOD_W-1:0]      due;
    if (item.req_type == REQ_SET) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!busy[i]) begin
          busy[i]        = 1'b1;
          base_time[i]   = clock_now;
          slot_period[i] = item.period;
          first_delay[i] = item.first_wait;
          delay_due[i]   = item.use_first_wait;
          loops_left[i]  = item.loop_total;
          endless[i]     = (item.loop_total == '0);
          add_result(KIND_SET_OK, i, 1'b1);
          return;
        end
      end
      add_result(KIND_FULL, 0, 1'b1);
      return;
    end
    clock_now = clock_now + TIME_BITS_DEF'(item.tick_amount);
    for (int i = 0; i < SLOTS; i++) begin
      if (!busy[i]) continue;
      elapsed = clock_now - base_time[i];
      due = delay_due[i] ? first_delay[i] : slot_period[i];
      if (elapsed < due) continue;
      delay_due[i] = 1'b0;
      if (!endless[i]) begin
        loops_left[i] = loops_left[i] - 1'b1;
        if (loops_left[i] == '0) begin
          busy[i] = 1'b0;
          add_result(KIND_FINISH, i, 1'b0);
          continue;
        end
      end
      base_time[i] = clock_now;
      add_result(KIND_RELOAD, i, 1'b0);
    end
    add_result(KIND_DONE, 0, 1'b1);
  endfunction

  always @(posedge clk) begin
    timer_result_t  got;
    timer_result_t  want;
    timer_request_t item;
    if (rst) begin
      clock_now = '0;
      foreach (busy[i]) busy[i] = 1'b0;
      expected_results.delete();
    end else begin
      // results first: the final result of one item may leave as the next item enters
      if (res.valid && res.ready) begin
        got.kind = res.res_kind;
        got.slot = res.slot_id;
        got.last = res.last_result;
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= SHOWN)
            $display("%0t: unexpected result kind %0d slot %0d last %0b", $time,
                     got.kind, got.slot, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot || got.last !== want.last) begin
            failures++;
            if (failures <= SHOWN)
              $display("%0t: result mismatch: expected kind %0d slot %0d last %0b, got kind %0d slot %0d last %0b",
                       $time, want.kind, want.slot, want.last, got.kind, got.slot, got.last);
          end
        end
      end
      if (req.valid && req.ready) begin
        item.req_type       = req.req_type;
        item.period         = req.period;
        item.loop_total     = req.loop_total;
        item.first_wait     = req.first_wait;
        item.use_first_wait = req.use_first_wait;
        item.tick_amount    = req.tick_amount;
        predict_request(item);
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= failures;
  end

endmodule

[sim/tb.sv]
// Testbench top for the loop timer: clock, reset, request stimulus and result-side stalls.
// Depends on timer_req_pkg, the channel interfaces, multi_slot_loop_timer and the checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import timer_req_pkg::*;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASE_ITEMS  = 48;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   stall_left = 0;
  bit   sink_steady = 1'b0;
  bit   source_steady = 1'b1;

  mslt_req_if req_if();
  mslt_res_if res_if();

  multi_slot_loop_timer u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if)
  );

  mslt_result_checker u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 4) == 0) begin
      stall_left <= pick_gap() - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  function automatic timer_request_t set_req(logic [31:0] period, logic [15:0] loops,
                                             logic [31:0] delay, logic use_delay);
    timer_request_t r;
    r.req_type       = REQ_SET;
    r.period         = period;
    r.loop_total     = loops;
    r.first_wait     = delay;
    r.use_first_wait = use_delay;
    r.tick_amount    = 16'($urandom);
    return r;
  endfunction

  function automatic timer_request_t tick_req(logic [15:0] amount);
    timer_request_t r;
    r.req_type       = REQ_TICK;
    r.period         = $urandom;
    r.loop_total     = 16'($urandom);
    r.first_wait     = $urandom;
    r.use_first_wait = 1'($urandom);
    r.tick_amount    = amount;
    return r;
  endfunction

  // mostly short-lived timers with small waits so slots fire and free often;
  // rare endless timers and rare fully random ones
  function automatic timer_request_t random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      return tick_req(($urandom_range(0, 29) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 40)));
    if (pick < 98)
      return set_req($urandom_range(0, 60), 16'($urandom_range(1, 6)),
                     $urandom_range(0, 60), 1'($urandom));
    if (pick < 99)
      return set_req($urandom_range(0, 60), '0, $urandom_range(0, 60), 1'($urandom));
    return set_req($urandom, 16'($urandom), $urandom, 1'($urandom));
  endfunction

  task automatic send(timer_request_t item);
    int idle;
    idle = (source_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (idle > 0) begin
      req_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= item.req_type;
    req_if.period         <= item.period;
    req_if.loop_total     <= item.loop_total;
    req_if.first_wait     <= item.first_wait;
    req_if.use_first_wait <= item.use_first_wait;
    req_if.tick_amount    <= item.tick_amount;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    timer_request_t plan[$];
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_SET;
    req_if.period         = '0;
    req_if.loop_total     = '0;
    req_if.first_wait     = '0;
    req_if.use_first_wait = 1'b0;
    req_if.tick_amount    = '0;
    res_if.ready          = 1'b0;

    plan.push_back(tick_req('0));
    plan.push_back(set_req('1, 16'd1, '0, 1'b1));
    plan.push_back(set_req('0, '0, '1, 1'b0));
    plan.push_back(set_req('0, '1, '0, 1'b0));
    plan.push_back(set_req(32'd1, 16'd3, 32'd5, 1'b1));
    // first delay still pending after this tick
    plan.push_back(tick_req(16'd2));
    repeat (13) plan.push_back(set_req('0, 16'd1, $urandom, 1'b0));
    plan.push_back(set_req($urandom, 16'($urandom), $urandom, 1'($urandom)));
    // every slot fires at once
    plan.push_back(tick_req(16'd3));
    plan.push_back(tick_req('1));
    plan.push_back(tick_req('0));
    plan.push_back(tick_req(16'd1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send(plan[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        source_steady = ($urandom_range(0, 3) == 0);
        sink_steady <= ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) wait_all_results();
      send(random_req());
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[multi_slot_loop_timer.f]
+incdir+rtl/core
rtl/core/mslt_pkg.sv
rtl/core/mslt_if.sv
rtl/core/mslt_datapath.sv
rtl/core/mslt_ctrl.sv
rtl/core/multi_slot_loop_timer.sv
sim/timer_req_pkg.sv
sim/mslt_result_checker.sv
sim/tb.sv
